>>> hw/rtl/ucla_pkg.sv
// Shared codes, constants and controller/datapath interface types.
`timescale 1ns / 1ps

package ucla_pkg;

    // Default line store depth
    localparam int LINE_DEPTH_DEF = 32;

    // Operation codes on the input tuser
    localparam logic [1:0] OP_RX     = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // Event codes on the output tuser
    localparam logic [1:0] EV_LINE   = 2'd0;
    localparam logic [1:0] EV_ERROR  = 2'd1;
    localparam logic [1:0] EV_STATUS = 2'd2;

    // Special characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // What an incoming transaction will do
    typedef enum logic [2:0] {
        K_NONE,      // ignored, no result
        K_CLEAR,     // clear sticky status
        K_STATUS,    // status report
        K_FLAG,      // error flags with the byte
        K_FULL,      // byte found the store full
        K_STORE,     // byte goes into the line store
        K_LF_EMPTY,  // line feed on an empty line
        K_LINE       // line feed, walk the stored line out
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic rd_en;      // read line store at the walk index
        logic load_byte;  // load read data into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  out_free;   // output register can take a result this cycle
        logic  last_byte;  // walk index is on the final stored byte
    } sts_t;

endpackage

>>> hw/rtl/ucla_ctrl.sv
// Controller: accepts transactions and sequences the line walk.
`timescale 1ns / 1ps

module ucla_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ucla_pkg::sts_t sts,
    output ucla_pkg::cmd_t cmd
);
    import ucla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Command decode and next state
    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.load_byte = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = sts.out_free;
                cmd.take = s_tvalid && sts.out_free;
                if (cmd.take && sts.kind == K_LINE) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next    = sts.last_byte ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/ucla_dp.sv
// Datapath: line store, fill count, sticky status and output register.
`timescale 1ns / 1ps

module ucla_dp #(
    parameter int LINE_DEPTH = ucla_pkg::LINE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [15:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    input  ucla_pkg::cmd_t cmd,
    output ucla_pkg::sts_t sts,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);
    import ucla_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int FW = $clog2(LINE_DEPTH + 1);

    // Input fields
    logic [7:0] rx_byte;
    logic [3:0] flags;
    assign rx_byte = s_tdata[7:0];
    assign flags   = s_tdata[11:8];

    logic [7:0]    mem [LINE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [3:0]    status_reg, status_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          out_valid_reg;
    logic [1:0]    out_ev_reg;
    logic [7:0]    out_byte_reg;
    logic [4:0]    out_idx_reg;
    logic [5:0]    out_len_reg;
    logic [3:0]    out_status_reg;
    logic          out_last_reg;

    kind_t kind;
    logic  last_byte;
    logic  load_single;
    logic  load_any;

    // Classify the incoming transaction
    always_comb begin
        case (s_tuser)
            OP_CLEAR:  kind = K_CLEAR;
            OP_STATUS: kind = K_STATUS;
            OP_RX: begin
                if (flags != 4'd0) begin
                    kind = K_FLAG;
                end else if (status_reg != 4'd0) begin
                    kind = K_NONE;
                end else if (rx_byte == CH_SPACE || rx_byte == CH_CR) begin
                    kind = K_NONE;
                end else if (rx_byte == CH_LF) begin
                    kind = (fill_reg == '0) ? K_LF_EMPTY : K_LINE;
                end else if (fill_reg >= FW'(LINE_DEPTH)) begin
                    kind = K_FULL;
                end else begin
                    kind = K_STORE;
                end
            end
            default:   kind = K_NONE;
        endcase
    end

    assign last_byte = (FW'(idx_reg) + FW'(1)) == fill_reg;

    assign sts.kind      = kind;
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.last_byte = last_byte;

    assign load_single = cmd.take && (kind == K_STATUS || kind == K_FLAG ||
                                      kind == K_FULL || kind == K_LF_EMPTY);
    assign load_any    = load_single || cmd.load_byte;

    // Next values of fill count, status and walk index
    always_comb begin
        fill_next   = fill_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        if (cmd.take) begin
            case (kind)
                K_CLEAR: status_next = 4'd0;
                K_FLAG: begin
                    status_next = status_reg | flags;
                    fill_next   = '0;
                end
                K_FULL:  fill_next = '0;
                K_STORE: fill_next = fill_reg + FW'(1);
                K_LINE:  idx_next  = '0;
                default: ;
            endcase
        end
        if (cmd.load_byte) begin
            if (last_byte) begin
                fill_next = '0;
                idx_next  = '0;
            end else begin
                idx_next = idx_reg + AW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            status_reg    <= 4'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
            if (load_any) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Line store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.take && kind == K_STORE) begin
            mem[fill_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            out_ev_reg     <= EV_LINE;
            out_byte_reg   <= rd_data_reg;
            out_idx_reg    <= 5'(idx_reg);
            out_len_reg    <= 6'(fill_reg);
            out_status_reg <= status_reg;
            out_last_reg   <= last_byte;
        end else if (load_single) begin
            case (kind)
                K_STATUS:   out_ev_reg <= EV_STATUS;
                K_LF_EMPTY: out_ev_reg <= EV_LINE;
                default:    out_ev_reg <= EV_ERROR;
            endcase
            out_byte_reg   <= 8'd0;
            out_idx_reg    <= 5'd0;
            out_len_reg    <= 6'd0;
            out_status_reg <= status_next;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_len_reg, out_idx_reg, out_byte_reg};

endmodule

>>> hw/rtl/uart_command_line_assembler.sv
// UART command line assembler: stream in received bytes, stream out lines.
// Input channel s_*: one transaction per UART event. s_tuser carries the
// operation (received byte, clear status, read status); s_tdata carries the
// byte and four receive error flags. Output channel m_*: one transaction per
// result; m_tuser is the event kind, m_tlast marks the end of a run.
// A stored byte, space, carriage return or status clear is accepted and
// gives no result. An error or status report appears in the output register
// in the cycle after acceptance. A line feed walks the line store out byte
// by byte: a registered memory read, then a load into the output register,
// which waits while the output register is still held by the receiver.
// Input is taken only while the walk is idle and the output register is free
// or being emptied in the same cycle; a stalled receiver holds the result in
// the output register and stops the walk and the input.
// Reset clears the fill count, the sticky status and the output register;
// the line store needs no clearing since only written entries are read.
`timescale 1ns / 1ps

module uart_command_line_assembler #(
    parameter int LINE_DEPTH = ucla_pkg::LINE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte[7:0], err_parity[8], err_framing[9], err_noise[10],
    // err_overrun[11], zero fill[15:12]
    input  logic [15:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_byte[7:0], byte_index[12:8], line_length[18:13],
    // status_bits[22:19], zero fill[23]
    output logic [23:0] m_tdata,
    // event_res[1:0]
    output logic [1:0]  m_tuser,
    // last
    output logic        m_tlast
);
    import ucla_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ucla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ucla_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // No input is taken while the line walk is running
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.rd_en || cmd.load_byte))
        else $error("input ready during line walk");

    // A store read is always followed by a load cycle, not by input
    a_read_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> !s_tready)
        else $error("input ready right after a store read");

    // Error and status results are single-transaction runs
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_ERROR || m_tuser == EV_STATUS)) |-> m_tlast)
        else $error("error or status result without last");
`endif

endmodule

>>> bench/uart_command_line_assembler_tb.sv
// Self-checking testbench for the UART command line assembler.
`timescale 1ns / 1ps

module uart_command_line_assembler_tb;
    import ucla_pkg::*;

    localparam int          LINE_DEPTH = LINE_DEPTH_DEF;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;     // undefined operation, ignored
    localparam int          EFFECTIVE_ITEMS = 350; // random input items to send
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          END_WAIT = 50_000;
    localparam int          SETTLE_CYCLES = 2 * LINE_DEPTH + 8;

    // One result as it appears on the master side
    typedef struct packed {
        logic [1:0] ev_kind;
        logic [7:0] chr;
        logic [4:0] idx;
        logic [5:0] len;
        logic [3:0] status;
        logic       last;
    } line_result_t;

    // Line assembly predictor plus the store of results still to come
    class line_scoreboard;
        logic [7:0]   line_mem [LINE_DEPTH];
        int unsigned  fill;
        logic [3:0]   sticky;
        line_result_t pending_results [$];
        int           errors;
        int           reported;

        function new();
            fill     = 0;
            sticky   = 4'd0;
            errors   = 0;
            reported = 0;
        endfunction

        function void push_result(logic [1:0] ev, logic [7:0] chr, int unsigned idx,
                                  int unsigned len, logic last);
            line_result_t r;
            r.ev_kind = ev;
            r.chr     = chr;
            r.idx     = idx[4:0];
            r.len     = len[5:0];
            r.status  = sticky;
            r.last    = last;
            pending_results.push_back(r);
        endfunction

        // Accepted input transaction; returns 1 unless the block ignores it
        function bit note_rx_item(logic [1:0] op, logic [15:0] data);
            logic [7:0] chr;
            logic [3:0] flags;
            chr   = data[7:0];
            flags = data[11:8];
            case (op)
                OP_CLEAR: begin
                    sticky = 4'd0;
                    return 1'b1;
                end
                OP_STATUS: begin
                    push_result(EV_STATUS, 8'd0, 0, 0, 1'b1);
                    return 1'b1;
                end
                OP_RX: ;
                default: return 1'b0;
            endcase
            // error flags win over everything, even a line feed
            if (flags != 4'd0) begin
                sticky = sticky | flags;
                fill   = 0;
                push_result(EV_ERROR, 8'd0, 0, 0, 1'b1);
                return 1'b1;
            end
            if (sticky != 4'd0) return 1'b0;
            if (chr == CH_SPACE || chr == CH_CR) return 1'b0;
            if (chr == CH_LF) begin
                if (fill == 0) begin
                    push_result(EV_LINE, 8'd0, 0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++)
                        push_result(EV_LINE, line_mem[i], i, fill, i == fill - 1);
                end
                fill = 0;
                return 1'b1;
            end
            // overflow drops the line, status untouched
            if (fill >= LINE_DEPTH) begin
                fill = 0;
                push_result(EV_ERROR, 8'd0, 0, 0, 1'b1);
                return 1'b1;
            end
            line_mem[fill] = chr;
            fill++;
            return 1'b1;
        endfunction

        function void check_result(logic [23:0] d, logic [1:0] u, logic l);
            line_result_t got;
            line_result_t want;
            got.ev_kind = u;
            got.chr     = d[7:0];
            got.idx     = d[12:8];
            got.len     = d[18:13];
            got.status  = d[22:19];
            got.last    = l;
            if (pending_results.size() == 0) begin
                errors++;
                if (reported < 10)
                    $display("unexpected result: ev=%0d byte=%02h idx=%0d len=%0d st=%h last=%0d",
                             got.ev_kind, got.chr, got.idx, got.len, got.status, got.last);
                reported++;
                return;
            end
            want = pending_results.pop_front();
            if (got.ev_kind !== want.ev_kind || got.chr !== want.chr ||
                got.idx !== want.idx || got.len !== want.len ||
                got.status !== want.status || got.last !== want.last) begin
                errors++;
                if (reported < 10)
                    $display("mismatch: exp ev=%0d byte=%02h idx=%0d len=%0d st=%h last=%0d, %s",
                             want.ev_kind, want.chr, want.idx, want.len, want.status,
                             want.last, $sformatf("got ev=%0d byte=%02h idx=%0d len=%0d st=%h last=%0d",
                             got.ev_kind, got.chr, got.idx, got.len, got.status, got.last));
                reported++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;
    logic [1:0]  s_tuser  = OP_RX;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    line_scoreboard sb = new();
    int effective_items = 0;
    int burst_left = 0;
    int stall_left = 0;
    int ready_run = 0;
    int cycle_count = 0;

    uart_command_line_assembler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** uart_command_line_assembler: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, short mostly, some long, some stall-free runs
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            int r;
            m_tready = 1'b1;
            r = $urandom_range(0, 99);
            if (ready_run > 0) begin
                ready_run--;
            end else if (r < 25) begin
                stall_left = $urandom_range(1, 3);
            end else if (r < 29) begin
                stall_left = $urandom_range(10, 40);
            end else if (r < 33) begin
                ready_run = $urandom_range(20, 80);
            end
        end
    end

    // Result check on every master-side transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    function automatic logic [15:0] rx_word(logic [7:0] chr, logic [3:0] flags);
        return {4'd0, flags, chr};
    endfunction

    // Sender gap: none inside a burst, otherwise short mostly and a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (r < 8) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // One input transaction; called and returns at a falling edge
    task automatic send_item(logic [1:0] op, logic [15:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        void'(sb.note_rx_item(op, data));
        effective_items++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Random line of len bytes, LF-terminated unless told otherwise
    task automatic send_line(int len, bit allow_drop, bit terminate);
        logic [7:0] chr;
        for (int i = 0; i < len; i++) begin
            chr = 8'($urandom_range(0, 255));
            if (chr == CH_LF) chr = 8'h41;
            if (allow_drop && $urandom_range(0, 99) < 8)
                chr = $urandom_range(0, 1) ? CH_SPACE : CH_CR;
            send_item(OP_RX, rx_word(chr, 4'd0));
        end
        if (terminate) send_item(OP_RX, rx_word(CH_LF, 4'd0));
    endtask

    initial begin
        int wait_cycles;
        int r;
        int len;
        int line_no;

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty line, extremes, dropped chars, errors, ignored bytes
        send_item(OP_RX, rx_word(CH_LF, 4'd0));
        send_item(OP_STATUS, 16'h0000);
        send_item(OP_RX, rx_word(8'h00, 4'd0));
        send_item(OP_RX, rx_word(8'hFF, 4'd0));
        send_item(OP_RX, rx_word(CH_SPACE, 4'd0));
        send_item(OP_RX, rx_word(8'h41, 4'd0));
        send_item(OP_RX, rx_word(CH_CR, 4'd0));
        send_item(OP_RX, rx_word(8'h7F, 4'd0));
        send_item(OP_RX, rx_word(CH_LF, 4'd0));
        send_item(OP_UNUSED, 16'h0FFF);
        send_item(OP_CLEAR, 16'h0000);
        send_item(OP_RX, rx_word(8'h78, 4'd0));
        send_item(OP_RX, rx_word(8'h79, 4'b0001));
        send_item(OP_RX, rx_word(8'h7A, 4'd0));
        send_item(OP_RX, rx_word(CH_LF, 4'd0));
        send_item(OP_STATUS, 16'h0000);
        send_item(OP_RX, rx_word(CH_LF, 4'b1110));
        send_item(OP_STATUS, 16'h0000);
        send_item(OP_CLEAR, 16'h0000);
        send_item(OP_STATUS, 16'h0000);
        send_item(OP_RX, rx_word(8'h31, 4'd0));
        send_item(OP_RX, rx_word(CH_LF, 4'd0));
        wait_results_drained();

        // Random: mostly well-formed lines, plus errors, status traffic and noise
        effective_items = 0;
        line_no = 0;
        while (effective_items < EFFECTIVE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // first two lines hit a full store and one past it
                if (line_no == 0) begin
                    send_line(LINE_DEPTH, 1'b0, 1'b1);
                end else if (line_no == 1) begin
                    send_line(LINE_DEPTH + 1, 1'b0, 1'b1);
                end else begin
                    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                       : $urandom_range(7, LINE_DEPTH + 2);
                    send_line(len, 1'b1, $urandom_range(0, 99) < 90);
                end
                line_no++;
            end else if (r < 80) begin
                send_item(OP_RX, rx_word(8'($urandom_range(0, 255)),
                                         4'($urandom_range(1, 15))));
                if ($urandom_range(0, 1)) send_item(OP_STATUS, 16'h0000);
                if ($urandom_range(0, 99) < 80) send_item(OP_CLEAR, 16'h0000);
            end else if (r < 88) begin
                send_item(OP_STATUS, 16'($urandom_range(0, 16'hFFFF)));
            end else if (r < 93) begin
                send_item(OP_CLEAR, 16'($urandom_range(0, 16'hFFFF)));
            end else if (r < 97) begin
                send_item(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
            end else begin
                wait_results_drained();
            end
        end

        // Let the block finish and the last results drain
        s_tvalid = 1'b0;
        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < END_WAIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending_results.size() != 0) begin
            sb.errors++;
            $display("%0d expected results never arrived", sb.pending_results.size());
        end

        if (sb.errors == 0) begin
            $display("** uart_command_line_assembler: PASSED **");
        end else begin
            $display("** uart_command_line_assembler: FAILED **");
        end
        $finish;
    end

endmodule
